FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error("assertion failed");

`endif

FILE: design/ccse_pkg.sv
// ---------------------------------------------------------------------------
// ccse_pkg
// Shared types and constants of the serial CRC codeword encoder.
// ---------------------------------------------------------------------------
package ccse_pkg;

    localparam int MAX_DEGREE = 32;
    localparam int POLY_W     = MAX_DEGREE + 1;
    localparam int KLEN_W     = 6;
    localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
    localparam int POS_W      = $clog2(MAX_DEGREE);

    localparam logic CFG_GEN_POLY = 1'b0;
    localparam logic CFG_KEY_LEN  = 1'b1;

    typedef logic [MAX_DEGREE-1:0] rem_t;

    typedef struct packed {
        logic [POLY_W-1:0] gen_poly;
        logic [KLEN_W-1:0] key_len;
    } cfg_t;

endpackage

FILE: design/ccse_div_step.sv
// ---------------------------------------------------------------------------
// ccse_div_step
// One modulo-2 division step of the remainder for a single data bit.
// ---------------------------------------------------------------------------
module ccse_div_step (
    input  ccse_pkg::cfg_t                 cfg,
    input  ccse_pkg::rem_t                 rem_in,
    input  logic                           data_bit,
    output ccse_pkg::rem_t                 rem_out,
    output logic [ccse_pkg::DEG_W-1:0]     degree
);

    logic [ccse_pkg::KLEN_W-1:0] klen;
    ccse_pkg::rem_t              mask;
    ccse_pkg::rem_t              rem_m;
    ccse_pkg::rem_t              taps;
    ccse_pkg::rem_t              shifted;
    logic [ccse_pkg::POS_W-1:0]  top_pos;
    logic                        fb;

    always_comb begin
        klen = cfg.key_len;
        if (klen < ccse_pkg::KLEN_W'(2)) begin
            klen = ccse_pkg::KLEN_W'(2);
        end else if (klen > ccse_pkg::KLEN_W'(ccse_pkg::MAX_DEGREE + 1)) begin
            klen = ccse_pkg::KLEN_W'(ccse_pkg::MAX_DEGREE + 1);
        end
        degree = klen - ccse_pkg::DEG_W'(1);

        if (degree == ccse_pkg::DEG_W'(ccse_pkg::MAX_DEGREE)) begin
            mask = '1;
        end else begin
            mask = (ccse_pkg::rem_t'(1) << degree) - ccse_pkg::rem_t'(1);
        end

        top_pos = ccse_pkg::POS_W'(degree - ccse_pkg::DEG_W'(1));
        rem_m   = rem_in & mask;
        taps    = cfg.gen_poly[ccse_pkg::MAX_DEGREE-1:0] & mask;
        fb      = rem_m[top_pos] ^ data_bit;
        shifted = (rem_m << 1) & mask;
        rem_out = fb ? (shifted ^ taps) : shifted;
    end

endmodule

FILE: design/crc_codeword_serial_encoder.sv
// ---------------------------------------------------------------------------
// crc_codeword_serial_encoder
// Bit-serial CRC encoder: data bits pass through, remainder bits follow.
// ---------------------------------------------------------------------------
//  channel  | signals                          | beat
//  s_       | tvalid tready tdata tlast        | one dataword bit
//  m_       | tvalid tready tdata tuser tlast  | one codeword bit
//  cfg_     | wr_en addr wdata                 | register write
//
//  One data bit per cycle while s_tready is high; a data beat appears
//  in the cycle after it is taken. After a tlast beat the input stalls
//  while the degree (clamped key_len-1) remainder bits shift out, MSB first.
//  Output register only advances when empty or m_tready is high.
//  Synchronous active-low reset: remainder cleared, gen_poly 11, key_len 4.
// ---------------------------------------------------------------------------
module crc_codeword_serial_encoder (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [0] data_bit
    input  logic                              s_tlast,   // last_bit

    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [0] code_bit
    output logic [0:0]                        m_tuser,   // [0] is_remainder
    output logic                              m_tlast,   // code_last

    input  logic                              cfg_wr_en,
    input  logic [0:0]                        cfg_addr,
    input  logic [ccse_pkg::POLY_W-1:0]       cfg_wdata
);

    ccse_pkg::cfg_t                  cfg_reg;
    ccse_pkg::rem_t                  remainder_reg;
    ccse_pkg::rem_t                  rem_step;
    ccse_pkg::rem_t                  shift_reg;
    logic [ccse_pkg::DEG_W-1:0]      degree;
    logic [ccse_pkg::DEG_W-1:0]      cnt_reg;
    logic [ccse_pkg::POS_W-1:0]      emit_pos;
    logic                            out_valid_reg;
    logic                            out_bit_reg;
    logic                            out_rem_reg;
    logic                            out_last_reg;
    logic                            load;
    logic                            emitting;
    logic                            in_fire;

    ccse_div_step u_step (
        .cfg      (cfg_reg),
        .rem_in   (remainder_reg),
        .data_bit (s_tdata[0]),
        .rem_out  (rem_step),
        .degree   (degree)
    );

    assign load     = !out_valid_reg || m_tready;
    assign emitting = (cnt_reg != '0);
    assign s_tready = load && !emitting;
    assign in_fire  = s_tvalid && s_tready;
    assign emit_pos = ccse_pkg::POS_W'(cnt_reg - ccse_pkg::DEG_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gen_poly <= ccse_pkg::POLY_W'(11);
            cfg_reg.key_len  <= ccse_pkg::KLEN_W'(4);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr[0])
                ccse_pkg::CFG_GEN_POLY: cfg_reg.gen_poly <= cfg_wdata;
                ccse_pkg::CFG_KEY_LEN:  cfg_reg.key_len  <=
                                            cfg_wdata[ccse_pkg::KLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remainder_reg <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (emitting && load) begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= cnt_reg - ccse_pkg::DEG_W'(1);
            end else if (in_fire) begin
                out_valid_reg <= 1'b1;
                remainder_reg <= s_tlast ? '0 : rem_step;
                if (s_tlast) begin
                    cnt_reg <= degree;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (emitting && load) begin
            out_bit_reg  <= shift_reg[emit_pos];
            out_rem_reg  <= 1'b1;
            out_last_reg <= (cnt_reg == ccse_pkg::DEG_W'(1));
        end else if (in_fire) begin
            out_bit_reg  <= s_tdata[0];
            out_rem_reg  <= 1'b0;
            out_last_reg <= 1'b0;
            if (s_tlast) begin
                shift_reg <= rem_step;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_bit_reg};
    assign m_tuser  = out_rem_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: design/ccse_checker.sv
// ---------------------------------------------------------------------------
// ccse_checker
// Port-level assertions for the serial CRC codeword encoder.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ccse_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser,
    input logic       m_tlast
);

    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_NEXT(a_last_stalls, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready)
    `ASSERT_NEXT(a_data_beat, aclk, aresetn, s_tvalid && s_tready, m_tvalid && !m_tuser[0])
    `ASSERT_IMPLY(a_rem_busy, aclk, aresetn, m_tvalid && m_tuser[0] && !m_tlast, !s_tready)
    `ASSERT_IMPLY(a_last_is_rem, aclk, aresetn, m_tvalid && m_tlast, m_tuser[0])

endmodule

bind crc_codeword_serial_encoder ccse_checker u_ccse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
